>>> hdl/qrs_pkg.sv
// Shared constants, word types and case codes of the quadratic root solver.
`timescale 1ns / 1ps
`default_nettype none
package qrs_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COEF_WIDTH = 32;
  localparam int TOL_W      = 16;
  localparam int PROD_W     = 2 * COEF_WIDTH + 2;
  localparam int ROOT_W     = PROD_W / 2;
  localparam int SQ_REM_W   = ROOT_W + 3;
  localparam int NUM_W      = ROOT_W + 1;
  localparam int DEN_W      = COEF_WIDTH + 1;
  localparam int DVD_W      = NUM_W + FRAC_BITS;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_ONE  = 2'd1,
    KIND_TWO  = 2'd2,
    KIND_INF  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    SEL0_NONE   = 2'd0,
    SEL0_LIN    = 2'd1,
    SEL0_VERTEX = 2'd2,
    SEL0_PLUS   = 2'd3
  } sel0_t;

  typedef enum logic [1:0] {
    SEL1_NONE  = 2'd0,
    SEL1_CZERO = 2'd1,
    SEL1_MINUS = 2'd2
  } sel1_t;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] coef_a;
    logic signed [COEF_WIDTH-1:0] coef_b;
    logic signed [COEF_WIDTH-1:0] coef_c;
  } in_t;

  typedef struct packed {
    logic [1:0]                   root_kind;
    logic signed [COEF_WIDTH-1:0] root_one;
    logic signed [COEF_WIDTH-1:0] root_two;
    logic                         saturated;
  } out_t;

  typedef struct packed {
    kind_t                        kind;
    sel0_t                        sel0;
    sel1_t                        sel1;
    logic signed [COEF_WIDTH-1:0] sa;
    logic signed [COEF_WIDTH-1:0] sb;
    logic signed [COEF_WIDTH-1:0] sc;
  } meta_t;

  typedef struct packed {
    meta_t                meta;
    logic [PROD_W-1:0]    rad;
    logic [SQ_REM_W-1:0]  rem;
    logic [ROOT_W-1:0]    root;
  } sq_t;

  typedef struct packed {
    logic [DVD_W-1:0] dvd;
    logic [DEN_W-1:0] rem;
    logic [DVD_W-1:0] quo;
    logic [DEN_W-1:0] den;
    logic             neg;
    logic             used;
  } lane_t;

  typedef struct packed {
    kind_t kind;
    lane_t l0;
    lane_t l1;
  } dv_t;

endpackage
`default_nettype wire

>>> hdl/quadratic_root_solver.sv
// Top level of the quadratic root solver: register, cell chains and result stage.
`timescale 1ns / 1ps
`default_nettype none
// A new coefficient word is taken in every clock cycle and busy stays low. Each result
// leaves in order, with out_valid high for one cycle, after passing the square-root
// chain of 33 cells and the divider chain of 50 cells, one bit per cell. The receiver
// cannot stall the block. The tolerance register is to be written through cfg_valid
// and cfg_data only while no word is in flight: a user rule the block does not enforce.
module quadratic_root_solver (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire qrs_pkg::in_t                in_word,
  output logic                             out_valid,
  output qrs_pkg::out_t                    out_word,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [qrs_pkg::TOL_W-1:0]   cfg_data
);
  localparam int W  = qrs_pkg::COEF_WIDTH;
  localparam int R  = qrs_pkg::ROOT_W;
  localparam int NW = qrs_pkg::NUM_W;
  localparam int NS = NW + 1;
  localparam int DN = qrs_pkg::DEN_W;
  localparam int DS = DN + 1;
  localparam int DV = qrs_pkg::DVD_W;

  logic [qrs_pkg::TOL_W-1:0] tol_r, tol_eff;
  logic [R:0]                sq_vld;
  qrs_pkg::sq_t              sq_st [0:R];
  logic [DV:0]               dv_vld;
  qrs_pkg::dv_t              dv_st [0:DV];
  logic                      dv_vld0_r;
  qrs_pkg::dv_t              dv_st0_r;
  qrs_pkg::dv_t              prep_nxt;
  qrs_pkg::out_t             out_nxt;
  qrs_pkg::meta_t            m;
  logic signed [NS-1:0]      sbn, scn, se, n0, n1;
  logic signed [DS-1:0]      da, d2a, dbb, d0, d1;
  logic                      sat0, sat1;
  logic signed [W-1:0]       r0, r1;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign tol_eff   = (tol_r == '0) ? qrs_pkg::TOL_W'(1) : tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= qrs_pkg::TOL_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      tol_r <= cfg_data;
    end
  end

  qrs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start && !busy),
    .in_w    (in_word),
    .tol     (tol_eff),
    .out_vld (sq_vld[0]),
    .out_st  (sq_st[0])
  );

  for (genvar i = 0; i < R; i++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (sq_vld[i]),
      .in_st   (sq_st[i]),
      .out_vld (sq_vld[i+1]),
      .out_st  (sq_st[i+1])
    );
  end

  function automatic qrs_pkg::lane_t mk_lane(logic signed [NS-1:0] n,
                                             logic signed [DS-1:0] d, logic used);
    logic [NS-1:0]  nm;
    logic [DS-1:0]  dm;
    qrs_pkg::lane_t l;
    nm     = n[NS-1] ? (~n + 1'b1) : n;
    dm     = d[DS-1] ? (~d + 1'b1) : d;
    l.dvd  = {NW'(nm), {qrs_pkg::FRAC_BITS{1'b0}}};
    l.rem  = '0;
    l.quo  = '0;
    l.den  = DN'(dm);
    l.neg  = n[NS-1] ^ d[DS-1];
    l.used = used;
    return l;
  endfunction

  always_comb begin
    m   = sq_st[R].meta;
    sbn = NS'(m.sb);
    scn = NS'(m.sc);
    se  = $signed({{(NS-R){1'b0}}, sq_st[R].root});
    da  = DS'(m.sa);
    d2a = da <<< 1;
    dbb = DS'(m.sb);
    unique case (m.sel0)
      qrs_pkg::SEL0_LIN:    begin n0 = -scn;     d0 = dbb; end
      qrs_pkg::SEL0_VERTEX: begin n0 = -sbn;     d0 = d2a; end
      qrs_pkg::SEL0_PLUS:   begin n0 = se - sbn; d0 = d2a; end
      default:              begin n0 = '0;       d0 = d2a; end
    endcase
    unique case (m.sel1)
      qrs_pkg::SEL1_CZERO: begin n1 = -sbn;      d1 = da;  end
      qrs_pkg::SEL1_MINUS: begin n1 = -sbn - se; d1 = d2a; end
      default:             begin n1 = '0;        d1 = d2a; end
    endcase
    prep_nxt.kind = m.kind;
    prep_nxt.l0   = mk_lane(n0, d0, m.sel0 != qrs_pkg::SEL0_NONE);
    prep_nxt.l1   = mk_lane(n1, d1, m.sel1 != qrs_pkg::SEL1_NONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld0_r <= 1'b0;
    end else begin
      dv_vld0_r <= sq_vld[R];
    end
  end

  always_ff @(posedge clk) begin
    dv_st0_r <= prep_nxt;
  end

  assign dv_vld[0] = dv_vld0_r;
  assign dv_st[0]  = dv_st0_r;

  for (genvar j = 0; j < DV; j++) begin : g_div
    qrs_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (dv_vld[j]),
      .in_st   (dv_st[j]),
      .out_vld (dv_vld[j+1]),
      .out_st  (dv_st[j+1])
    );
  end

  function automatic logic signed [W-1:0] finish(qrs_pkg::lane_t l, output logic sat);
    logic [W-1:0] lim, qs;
    lim    = l.neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    sat    = l.used && (l.quo > DV'(lim));
    qs     = (l.quo > DV'(lim)) ? lim : l.quo[W-1:0];
    if (!l.used) begin
      return '0;
    end
    return l.neg ? $signed(~qs + 1'b1) : $signed(qs);
  endfunction

  always_comb begin
    r0 = finish(dv_st[DV].l0, sat0);
    r1 = finish(dv_st[DV].l1, sat1);
    out_nxt.root_kind = dv_st[DV].kind;
    out_nxt.root_one  = r0;
    out_nxt.root_two  = r1;
    out_nxt.saturated = sat0 | sat1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv_vld[DV];
    end
  end

  always_ff @(posedge clk) begin
    out_word <= out_nxt;
  end

  a_no_root_values: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_word.root_kind == qrs_pkg::KIND_NONE ||
                   out_word.root_kind == qrs_pkg::KIND_INF))
    |-> (out_word.root_one == '0 && out_word.root_two == '0))
    else $error("root value present without a root");

  a_sat_needs_root: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.saturated)
    |-> (out_word.root_kind == qrs_pkg::KIND_ONE || out_word.root_kind == qrs_pkg::KIND_TWO))
    else $error("saturation flagged without a root");

  a_one_root_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.root_kind == qrs_pkg::KIND_ONE) |-> (out_word.root_two == '0))
    else $error("second root set for a single root");

endmodule
`default_nettype wire

>>> hdl/qrs_front.sv
// Front end: zero tests, coefficient products, discriminant and case decision.
`timescale 1ns / 1ps
`default_nettype none
module qrs_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_vld,
  input  wire qrs_pkg::in_t                in_w,
  input  wire logic [qrs_pkg::TOL_W-1:0]   tol,
  output logic                             out_vld,
  output qrs_pkg::sq_t                     out_st
);
  localparam int W = qrs_pkg::COEF_WIDTH;
  localparam int P = qrs_pkg::PROD_W;

  logic [W-1:0]   ma, mb, mc;
  logic           vld0_r;
  logic signed [W-1:0] sa_r, sb_r, sc_r;
  logic           za_r, zb_r, zc_r, sdiff_r;
  logic [2*W-1:0] b2_r, ac_r;
  logic [P-1:0]   b2e, ac4, dm, tz;
  logic           dneg, dzero;
  qrs_pkg::sq_t   st_nxt;

  always_comb begin
    ma = in_w.coef_a[W-1] ? (~in_w.coef_a + 1'b1) : in_w.coef_a;
    mb = in_w.coef_b[W-1] ? (~in_w.coef_b + 1'b1) : in_w.coef_b;
    mc = in_w.coef_c[W-1] ? (~in_w.coef_c + 1'b1) : in_w.coef_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    sa_r    <= in_w.coef_a;
    sb_r    <= in_w.coef_b;
    sc_r    <= in_w.coef_c;
    za_r    <= ma < W'(tol);
    zb_r    <= mb < W'(tol);
    zc_r    <= mc < W'(tol);
    sdiff_r <= in_w.coef_a[W-1] ^ in_w.coef_c[W-1];
    b2_r    <= mb * mb;
    ac_r    <= ma * mc;
  end

  always_comb begin
    b2e  = {2'b00, b2_r};
    ac4  = {ac_r, 2'b00};
    dneg = 1'b0;
    if (sdiff_r) begin
      dm = b2e + ac4;
    end else if (b2e >= ac4) begin
      dm = b2e - ac4;
    end else begin
      dm   = ac4 - b2e;
      dneg = 1'b1;
    end
    tz    = P'(tol) << qrs_pkg::FRAC_BITS;
    dzero = dm < tz;

    st_nxt.meta.kind = qrs_pkg::KIND_NONE;
    st_nxt.meta.sel0 = qrs_pkg::SEL0_NONE;
    st_nxt.meta.sel1 = qrs_pkg::SEL1_NONE;
    st_nxt.meta.sa   = sa_r;
    st_nxt.meta.sb   = sb_r;
    st_nxt.meta.sc   = sc_r;
    st_nxt.rad       = dm;
    st_nxt.rem       = '0;
    st_nxt.root      = '0;
    priority if (za_r) begin
      if (zb_r) begin
        st_nxt.meta.kind = zc_r ? qrs_pkg::KIND_INF : qrs_pkg::KIND_NONE;
      end else begin
        st_nxt.meta.kind = qrs_pkg::KIND_ONE;
        st_nxt.meta.sel0 = zc_r ? qrs_pkg::SEL0_NONE : qrs_pkg::SEL0_LIN;
      end
    end else if (zc_r) begin
      if (zb_r) begin
        st_nxt.meta.kind = qrs_pkg::KIND_ONE;
      end else begin
        st_nxt.meta.kind = qrs_pkg::KIND_TWO;
        st_nxt.meta.sel1 = qrs_pkg::SEL1_CZERO;
      end
    end else if (dzero) begin
      st_nxt.meta.kind = qrs_pkg::KIND_ONE;
      st_nxt.meta.sel0 = qrs_pkg::SEL0_VERTEX;
    end else if (!dneg) begin
      st_nxt.meta.kind = qrs_pkg::KIND_TWO;
      st_nxt.meta.sel0 = qrs_pkg::SEL0_PLUS;
      st_nxt.meta.sel1 = qrs_pkg::SEL1_MINUS;
    end else begin
      st_nxt.meta.kind = qrs_pkg::KIND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= vld0_r;
    end
  end

  always_ff @(posedge clk) begin
    out_st <= st_nxt;
  end

endmodule
`default_nettype wire

>>> hdl/qrs_sqrt_cell.sv
// One cell of the square-root chain: settles one root bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module qrs_sqrt_cell (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_vld,
  input  wire qrs_pkg::sq_t in_st,
  output logic              out_vld,
  output qrs_pkg::sq_t      out_st
);
  localparam int P  = qrs_pkg::PROD_W;
  localparam int R  = qrs_pkg::ROOT_W;
  localparam int RW = qrs_pkg::SQ_REM_W;

  logic [RW-1:0] cur, trial;
  logic          ge;
  qrs_pkg::sq_t  st_nxt;

  always_comb begin
    cur   = {in_st.rem[RW-3:0], in_st.rad[P-1 -: 2]};
    trial = {{(RW-R-2){1'b0}}, in_st.root, 2'b01};
    ge    = cur >= trial;
    st_nxt.meta = in_st.meta;
    st_nxt.rad  = {in_st.rad[P-3:0], 2'b00};
    st_nxt.rem  = ge ? (cur - trial) : cur;
    st_nxt.root = {in_st.root[R-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_st <= st_nxt;
  end

endmodule
`default_nettype wire

>>> hdl/qrs_div_cell.sv
// One cell of the divider chain: settles one quotient bit per cycle in both lanes.
`timescale 1ns / 1ps
`default_nettype none
module qrs_div_cell (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_vld,
  input  wire qrs_pkg::dv_t in_st,
  output logic              out_vld,
  output qrs_pkg::dv_t      out_st
);
  localparam int DV = qrs_pkg::DVD_W;
  localparam int DN = qrs_pkg::DEN_W;

  function automatic qrs_pkg::lane_t step(qrs_pkg::lane_t l);
    logic [DN:0]    cur;
    logic           ge;
    qrs_pkg::lane_t r;
    cur   = {l.rem, l.dvd[DV-1]};
    ge    = cur >= {1'b0, l.den};
    r     = l;
    r.dvd = {l.dvd[DV-2:0], 1'b0};
    r.rem = ge ? DN'(cur - {1'b0, l.den}) : DN'(cur);
    r.quo = {l.quo[DV-2:0], ge};
    return r;
  endfunction

  qrs_pkg::dv_t st_nxt;

  always_comb begin
    st_nxt.kind = in_st.kind;
    st_nxt.l0   = step(in_st.l0);
    st_nxt.l1   = step(in_st.l1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_st <= st_nxt;
  end

endmodule
`default_nettype wire
